// File: hdl/inverter_reply_frame_parser_top_assert.svh
// ---------------------------------------------------------------------------
// Reply frame parser assertion macros
// Shared assertion forms for the reply frame parser checks.
// ---------------------------------------------------------------------------
`ifndef INVERTER_REPLY_FRAME_PARSER_TOP_ASSERT_SVH
`define INVERTER_REPLY_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IRFP_ASSERT_HOLD(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("reply frame parser check failed");

// next-cycle implication, disabled in reset
`define IRFP_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("reply frame parser check failed");

`endif

// File: hdl/irfp_pkg.sv
// ---------------------------------------------------------------------------
// Reply frame parser package
// Types, character codes, label codes and helpers shared by the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package irfp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_CLOSE = 8'h7d;

  localparam logic [23:0] LBL_KT0 = 24'h4b5430;
  localparam logic [23:0] LBL_PAC = 24'h504143;
  localparam logic [23:0] LBL_UDC = 24'h554443;
  localparam logic [23:0] LBL_UL1 = 24'h554c31;
  localparam logic [23:0] LBL_IDC = 24'h494443;
  localparam logic [23:0] LBL_IL1 = 24'h494c31;
  localparam logic [23:0] LBL_PRL = 24'h50524c;
  localparam logic [23:0] LBL_TNF = 24'h544e46;
  localparam logic [23:0] LBL_TKK = 24'h544b4b;

  localparam logic [2:0] CODE_UDC    = 3'd0;
  localparam logic [2:0] CODE_UL1    = 3'd1;
  localparam logic [2:0] CODE_IDC    = 3'd2;
  localparam logic [2:0] CODE_IL1    = 3'd3;
  localparam logic [2:0] CODE_PRL    = 3'd4;
  localparam logic [2:0] CODE_TNF    = 3'd5;
  localparam logic [2:0] CODE_TKK    = 3'd6;
  localparam logic [2:0] CODE_ENERGY = 3'd7;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_ENERGY  = 2'd1;
  localparam logic [1:0] KIND_POWER   = 2'd2;
  localparam logic [1:0] KIND_READING = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] code;
  } label_info_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] value;
  } reading_t;

  typedef struct packed {
    logic        is_end;
    logic        commit;
    logic [2:0]  code;
    logic [31:0] value;
    logic [31:0] power;
  } irfp_event_t;

  function automatic label_info_t decode_label(input logic [23:0] lbl);
    label_info_t info;
    info = '{kind: KIND_NONE, code: CODE_UDC};
    unique case (lbl)
      LBL_KT0: info.kind = KIND_ENERGY;
      LBL_PAC: info.kind = KIND_POWER;
      LBL_UDC: info = '{kind: KIND_READING, code: CODE_UDC};
      LBL_UL1: info = '{kind: KIND_READING, code: CODE_UL1};
      LBL_IDC: info = '{kind: KIND_READING, code: CODE_IDC};
      LBL_IL1: info = '{kind: KIND_READING, code: CODE_IL1};
      LBL_PRL: info = '{kind: KIND_READING, code: CODE_PRL};
      LBL_TNF: info = '{kind: KIND_READING, code: CODE_TNF};
      LBL_TKK: info = '{kind: KIND_READING, code: CODE_TKK};
      default: info.kind = KIND_NONE;
    endcase
    return info;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    return (c >= 8'h41) ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

// File: hdl/irfp_queue.sv
// ---------------------------------------------------------------------------
// Reply frame parser event queue
// Small first-in first-out store between the byte parser and the emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irfp_queue
  import irfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  irfp_event_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output irfp_event_t head
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  irfp_event_t        slots [QUEUE_DEPTH];
  logic [QAW-1:0]     wptr;
  logic [QAW-1:0]     rptr;
  logic [QCW-1:0]     count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// File: hdl/irfp_front.sv
// ---------------------------------------------------------------------------
// Reply frame parser front end
// Parses reply bytes one per cycle while accept is high and posts readings and line ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irfp_front
  import irfp_pkg::*;
#(
  parameter int LINE_CAPACITY = 1024,
  parameter int PENDING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output irfp_event_t push_data
);

  localparam int LLW = $clog2(LINE_CAPACITY);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [LLW-1:0] line_length, line_length_next;
  logic [1:0]     phase, phase_next;
  logic [1:0]     skip_count, skip_count_next;
  logic [23:0]    token_label, token_label_next;
  logic [2:0]     label_length, label_length_next;
  logic [1:0]     part_count, part_count_next;
  logic [31:0]    hex_acc, hex_acc_next;
  logic [1:0]     token_count, token_count_next;
  logic [31:0]    energy_total, energy_total_next;
  logic [31:0]    power_raw, power_raw_next;
  logic [PCW-1:0] pend_count, pend_count_next;
  logic           piece_open, piece_open_next;
  logic           part_open, part_open_next;
  logic           hex_stopped, hex_stopped_next;
  logic [1:0]     part_upd;
  label_info_t    info;

  assign info = decode_label(token_label);

  always_comb begin
    line_length_next  = line_length;
    phase_next        = phase;
    skip_count_next   = skip_count;
    token_label_next  = token_label;
    label_length_next = label_length;
    part_count_next   = part_count;
    hex_acc_next      = hex_acc;
    token_count_next  = token_count;
    energy_total_next = energy_total;
    power_raw_next    = power_raw;
    pend_count_next   = pend_count;
    piece_open_next   = piece_open;
    part_open_next    = part_open;
    hex_stopped_next  = hex_stopped;
    part_upd          = part_count;
    push              = 1'b0;
    push_data         = '{is_end: 1'b0, commit: 1'b0, code: CODE_ENERGY,
                          value: energy_total, power: power_raw};
    if (accept && rx_byte != CH_CR) begin
      if (rx_byte == CH_CLOSE || line_length >= LLW'(LINE_CAPACITY - 1)) begin
        // line end
        push             = 1'b1;
        push_data.is_end = 1'b1;
        push_data.commit = (line_length != '0) && (phase == PH_DONE) &&
                           (token_count == 2'd2);
        line_length_next  = '0;
        phase_next        = PH_WAIT;
        skip_count_next   = '0;
        token_label_next  = '0;
        label_length_next = '0;
        part_count_next   = '0;
        hex_acc_next      = '0;
        token_count_next  = '0;
        energy_total_next = '0;
        power_raw_next    = '0;
        pend_count_next   = '0;
        piece_open_next   = 1'b0;
        part_open_next    = 1'b0;
        hex_stopped_next  = 1'b0;
      end else begin
        line_length_next = line_length + 1'b1;
        if (phase != PH_DONE) begin
          if (rx_byte == CH_NUL) begin
            phase_next       = PH_DONE;
            token_count_next = '0;
          end else begin
            unique case (phase)
              PH_WAIT: begin
                if (rx_byte == CH_BAR) begin
                  phase_next      = PH_SKIP;
                  skip_count_next = '0;
                end
              end
              PH_SKIP: begin
                if (skip_count >= 2'd2) begin
                  phase_next = PH_BODY;
                end else begin
                  skip_count_next = skip_count + 1'b1;
                end
              end
              PH_BODY: begin
                if (rx_byte == CH_BAR || rx_byte == CH_SEMI) begin
                  // piece end
                  if (piece_open) begin
                    if (token_count != 2'd2) begin
                      token_count_next = token_count + 1'b1;
                    end
                    if (part_count == 2'd2 && label_length == 3'd3) begin
                      case (info.kind)
                        KIND_ENERGY: energy_total_next = hex_acc;
                        KIND_POWER:  power_raw_next = hex_acc;
                        KIND_READING: begin
                          if (pend_count < PCW'(PENDING_DEPTH)) begin
                            push            = 1'b1;
                            push_data.code  = info.code;
                            push_data.value = hex_acc;
                            push_data.power = '0;
                            pend_count_next = pend_count + 1'b1;
                          end
                        end
                        default: ;
                      endcase
                    end
                  end
                  token_label_next  = '0;
                  label_length_next = '0;
                  part_count_next   = '0;
                  hex_acc_next      = '0;
                  piece_open_next   = 1'b0;
                  part_open_next    = 1'b0;
                  hex_stopped_next  = 1'b0;
                  if (rx_byte == CH_BAR) begin
                    phase_next = PH_DONE;
                  end
                end else begin
                  piece_open_next = 1'b1;
                  if (rx_byte == CH_EQ) begin
                    part_open_next = 1'b0;
                  end else begin
                    if (!part_open) begin
                      part_open_next = 1'b1;
                      if (part_count != 2'd3) begin
                        part_upd = part_count + 1'b1;
                      end
                    end
                    part_count_next = part_upd;
                    if (part_upd == 2'd1) begin
                      if (label_length < 3'd3) begin
                        token_label_next = {token_label[15:0], rx_byte};
                      end
                      if (label_length < 3'd4) begin
                        label_length_next = label_length + 1'b1;
                      end
                    end else if (part_upd == 2'd2 && !hex_stopped) begin
                      if (is_hex(rx_byte)) begin
                        hex_acc_next = {hex_acc[27:0], hex_value(rx_byte)};
                      end else begin
                        hex_stopped_next = 1'b1;
                      end
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      phase        <= PH_WAIT;
      skip_count   <= '0;
      token_label  <= '0;
      label_length <= '0;
      part_count   <= '0;
      hex_acc      <= '0;
      token_count  <= '0;
      energy_total <= '0;
      power_raw    <= '0;
      pend_count   <= '0;
      piece_open   <= 1'b0;
      part_open    <= 1'b0;
      hex_stopped  <= 1'b0;
    end else begin
      line_length  <= line_length_next;
      phase        <= phase_next;
      skip_count   <= skip_count_next;
      token_label  <= token_label_next;
      label_length <= label_length_next;
      part_count   <= part_count_next;
      hex_acc      <= hex_acc_next;
      token_count  <= token_count_next;
      energy_total <= energy_total_next;
      power_raw    <= power_raw_next;
      pend_count   <= pend_count_next;
      piece_open   <= piece_open_next;
      part_open    <= part_open_next;
      hex_stopped  <= hex_stopped_next;
    end
  end

endmodule

// File: hdl/irfp_back.sv
// ---------------------------------------------------------------------------
// Reply frame parser back end
// Holds a line's readings and emits them with the energy result at line end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irfp_back
  import irfp_pkg::*;
#(
  parameter int PENDING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  irfp_event_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  sensor_code,
  output logic [31:0] reading,
  output logic [31:0] ac_power_raw,
  output logic        last
);

  localparam int AW  = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int CW  = $clog2(PENDING_DEPTH + 2);

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_DRAIN = 1'b1;

  logic [0:0]     state;
  logic [PCW-1:0] wcnt;
  logic [CW-1:0]  idx, idx_next;
  logic [31:0]    energy;
  logic [31:0]    power;
  logic           has_energy;
  reading_t       mem [PENDING_DEPTH];
  reading_t       mem_q;
  logic           mem_we;
  logic           rd_ok;
  logic [CW-1:0]  n_total;
  logic           out_free;
  logic           load;
  logic           last_item;
  logic           from_mem;

  assign q_pop     = !q_empty && (state == ST_IDLE);
  assign mem_we    = q_pop && !q_head.is_end && (wcnt < PCW'(PENDING_DEPTH));
  assign n_total   = CW'(wcnt) + CW'(has_energy);
  assign out_free  = !out_valid || !out_stall;
  assign load      = (state == ST_DRAIN) && out_free;
  assign last_item = (idx == n_total - 1'b1);
  assign from_mem  = (idx < CW'(wcnt));
  assign rd_ok     = (idx_next < CW'(PENDING_DEPTH));

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = last_item ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wcnt       <= '0;
      idx        <= '0;
      has_energy <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.is_end) begin
              if (q_head.commit && (wcnt != '0 || q_head.value != '0)) begin
                state      <= ST_DRAIN;
                has_energy <= (q_head.value != '0);
              end else begin
                wcnt <= '0;
              end
            end else if (mem_we) begin
              wcnt <= wcnt + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (load && last_item) begin
            state <= ST_IDLE;
            wcnt  <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_end) begin
      energy <= q_head.value;
      power  <= q_head.power;
    end
    if (load) begin
      last <= last_item;
      if (from_mem) begin
        sensor_code  <= mem_q.code;
        reading      <= mem_q.value;
        ac_power_raw <= '0;
      end else begin
        sensor_code  <= CODE_ENERGY;
        reading      <= energy;
        ac_power_raw <= power;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wcnt[AW-1:0]] <= '{code: q_head.code, value: q_head.value};
    end
    if (rd_ok) begin
      mem_q <= mem[idx_next[AW-1:0]];
    end
  end

endmodule

// File: hdl/inverter_reply_frame_parser_top.sv
// ---------------------------------------------------------------------------
// Inverter reply frame parser
// Parses reply lines byte by byte and emits the readings of each line.
// ---------------------------------------------------------------------------
// Input channel: one reply byte per item on rx_byte, in_valid / in_stall.
// Output channel: sensor_code, reading, ac_power_raw, last per item,
// out_valid / out_stall. A line closes on '}' or at LINE_CAPACITY - 1
// stored bytes; its readings then leave in arrival order, followed by the
// energy result when the total is nonzero, last marking the final item.
// Throughput: one byte per cycle unless in_stall; results leave one per
// cycle unless out_stall. Readings and line ends pass a four-entry event
// queue; while the emitter runs a burst of up to PENDING_DEPTH + 1
// results the parser keeps taking bytes until that queue fills, then
// raises in_stall. A stall on the output holds the current result and,
// through the queue, eventually the input.
// Reset clears all parser state and the queue; no result is pending after it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverter_reply_frame_parser_top
  import irfp_pkg::*;
#(
  parameter int LINE_CAPACITY = 1024,
  parameter int PENDING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  sensor_code,
  output logic [31:0] reading,
  output logic [31:0] ac_power_raw,
  output logic        last
);

  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        ev_push;
  irfp_event_t ev_data;
  irfp_event_t q_head;

  assign in_stall = q_full;

  irfp_front #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_valid && !in_stall),
    .rx_byte  (rx_byte),
    .push     (ev_push),
    .push_data(ev_data)
  );

  irfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (ev_push),
    .push_data(ev_data),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  irfp_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sensor_code (sensor_code),
    .reading     (reading),
    .ac_power_raw(ac_power_raw),
    .last        (last)
  );

endmodule

// File: hdl/irfp_checker.sv
// ---------------------------------------------------------------------------
// Reply frame parser checker
// Port-level checks on the input and result channels, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "inverter_reply_frame_parser_top_assert.svh"

module irfp_checker
  import irfp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  sensor_code,
  input logic [31:0] reading,
  input logic [31:0] ac_power_raw,
  input logic        last
);

  logic [67:0] out_word;

  assign out_word = {sensor_code, reading, ac_power_raw, last};

  `IRFP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(rx_byte))
  `IRFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `IRFP_ASSERT_HOLD(a_power_energy_only, out_valid && sensor_code != CODE_ENERGY, ac_power_raw == '0)
  `IRFP_ASSERT_HOLD(a_energy_closes, out_valid && sensor_code == CODE_ENERGY, reading != '0 && last)
  `IRFP_ASSERT_HOLD(a_quiet_after_reset, $past(rst), !out_valid)

endmodule

bind inverter_reply_frame_parser_top irfp_checker u_irfp_checker (.*);
